@@ rtl/core/sdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants for the sum8 packet deframer
// Payload size, index widths, parser states and controller/datapath bundles.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int PAYLOAD_BYTES = 16;
  localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int BYTE_W        = 8;
  localparam int OUT_IDX_W     = 4;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PAYLOAD_BYTES - 1);
  localparam logic [BYTE_W-1:0] START_RESET = 8'h02;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SEQ,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_EMIT
  } parse_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic seed_sum;
    logic add_sum;
    logic cap_seq;
    logic cap_len;
    logic wr_data;
    logic clr_cnt;
    logic clr_rd;
    logic load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_start;
    logic sum_ok;
    logic wr_last;
    logic rd_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/core/sum8_packet_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sum8_packet_deframer: start-byte framed packet parser with 8-bit sum check
// Hunts for the start byte, takes sequence, length and PAYLOAD_BYTES payload
// bytes, checks the wrapping sum and emits the verified payload.
// ----------------------------------------------------------------------------
// Usage: one received byte per input transaction. While parsing a frame the
// block takes one byte per cycle. After a check byte that matches the running
// sum (start byte plus every byte up to the last payload byte, modulo 256),
// in_stall_o rises and the payload is delivered as PAYLOAD_BYTES (16) output
// transactions in index order, one per cycle unless out_stall_i holds them,
// from the single read port of the payload store; the input stays stalled
// until the last one is loaded. A mismatching check byte yields nothing and
// the parser hunts again without taking it as a start byte. The length byte
// is reported but does not size the payload. The user must write start_byte
// (reset 0x02) via cfg_we_i/cfg_data_i only while idle, which is not enforced.
// ----------------------------------------------------------------------------
module sum8_packet_deframer import sdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  // byte input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  // payload output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic [OUT_IDX_W-1:0] byte_index_o,
  output logic [BYTE_W-1:0]    command_code_o,
  output logic [BYTE_W-1:0]    sequence_number_o,
  output logic [BYTE_W-1:0]    length_field_o,
  output logic                 last_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Parser sequencing; issues one command set per cycle
  sdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Sum, header fields, payload store and output register
  sdf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .rx_byte_i         (rx_byte_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .payload_byte_o    (payload_byte_o),
    .byte_index_o      (byte_index_o),
    .command_code_o    (command_code_o),
    .sequence_number_o (sequence_number_o),
    .length_field_o    (length_field_o),
    .last_o            (last_o)
  );

endmodule

@@ rtl/core/sdf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_ctrl: frame parser state machine
// Walks hunt / sequence / length / payload / check, then drains the payload if the sum matches.
// ----------------------------------------------------------------------------
module sdf_ctrl import sdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  parse_state_e state_q, state_d;
  logic         accept;

  assign in_stall_o = (state_q == ST_EMIT);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_HUNT:  if (accept && status_i.is_start) state_d = ST_SEQ;
      ST_SEQ:   if (accept) state_d = ST_LEN;
      ST_LEN:   if (accept) state_d = ST_DATA;
      ST_DATA:  if (accept && status_i.wr_last) state_d = ST_CHECK;
      ST_CHECK: if (accept) state_d = status_i.sum_ok ? ST_EMIT : ST_HUNT;
      ST_EMIT:  if (status_i.out_free && status_i.rd_last) state_d = ST_HUNT;
      default:  state_d = ST_HUNT;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_HUNT: begin
        cmd_o.seed_sum = accept && status_i.is_start;
        cmd_o.clr_cnt  = accept && status_i.is_start;
      end
      ST_SEQ: begin
        cmd_o.add_sum = accept;
        cmd_o.cap_seq = accept;
      end
      ST_LEN: begin
        cmd_o.add_sum = accept;
        cmd_o.cap_len = accept;
      end
      ST_DATA: begin
        cmd_o.add_sum = accept;
        cmd_o.wr_data = accept;
      end
      ST_CHECK: begin
        cmd_o.clr_rd = accept;
      end
      ST_EMIT: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/core/sdf_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_dp: deframer datapath
// Running sum, header capture, payload store and the output register.
// ----------------------------------------------------------------------------
module sdf_dp import sdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    payload_byte_o,
  output logic [OUT_IDX_W-1:0] byte_index_o,
  output logic [BYTE_W-1:0]    command_code_o,
  output logic [BYTE_W-1:0]    sequence_number_o,
  output logic [BYTE_W-1:0]    length_field_o,
  output logic                 last_o
);

  logic [BYTE_W-1:0] start_q;
  logic [BYTE_W-1:0] sum_q;
  logic [BYTE_W-1:0] seq_q;
  logic [BYTE_W-1:0] len_q;
  logic [BYTE_W-1:0] cmd_q;
  logic [IDX_W-1:0]  wr_cnt_q;
  logic [IDX_W-1:0]  rd_cnt_q;
  logic [BYTE_W-1:0] store_q [PAYLOAD_BYTES];

  logic                 out_valid_q;
  logic [BYTE_W-1:0]    out_byte_q;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic [BYTE_W-1:0]    out_cmd_q;
  logic [BYTE_W-1:0]    out_seq_q;
  logic [BYTE_W-1:0]    out_len_q;
  logic                 out_last_q;

  assign status_o.is_start = (rx_byte_i == start_q);
  assign status_o.sum_ok   = (rx_byte_i == sum_q);
  assign status_o.wr_last  = (wr_cnt_q == IDX_LAST);
  assign status_o.rd_last  = (rd_cnt_q == IDX_LAST);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= START_RESET;
      sum_q       <= '0;
      seq_q       <= '0;
      len_q       <= '0;
      cmd_q       <= '0;
      wr_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i)       start_q <= cfg_data_i;
      if (cmd_i.seed_sum) sum_q <= rx_byte_i;
      else if (cmd_i.add_sum) sum_q <= sum_q + rx_byte_i;
      if (cmd_i.cap_seq)  seq_q <= rx_byte_i;
      if (cmd_i.cap_len)  len_q <= rx_byte_i;
      if (cmd_i.wr_data && (wr_cnt_q == '0)) cmd_q <= rx_byte_i;
      if (cmd_i.clr_cnt)  wr_cnt_q <= '0;
      else if (cmd_i.wr_data) wr_cnt_q <= wr_cnt_q + 1'b1;
      if (cmd_i.clr_rd)   rd_cnt_q <= '0;
      else if (cmd_i.load_out) rd_cnt_q <= rd_cnt_q + 1'b1;
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload store: write at the fill counter, read at the drain counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_data) store_q[wr_cnt_q] <= rx_byte_i;
    if (cmd_i.load_out) begin
      out_byte_q <= store_q[rd_cnt_q];
      out_idx_q  <= OUT_IDX_W'(rd_cnt_q);
      out_cmd_q  <= cmd_q;
      out_seq_q  <= seq_q;
      out_len_q  <= len_q;
      out_last_q <= (rd_cnt_q == IDX_LAST);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign payload_byte_o    = out_byte_q;
  assign byte_index_o      = out_idx_q;
  assign command_code_o    = out_cmd_q;
  assign sequence_number_o = out_seq_q;
  assign length_field_o    = out_len_q;
  assign last_o            = out_last_q;

endmodule

@@ rtl/core/sdf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_checker: port-level checks for the deframer
// Output hold under stall and burst ordering versus input stall.
// ----------------------------------------------------------------------------
module sdf_checker import sdf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [BYTE_W-1:0]    payload_byte_o,
  input logic [OUT_IDX_W-1:0] byte_index_o,
  input logic                 last_o
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(byte_index_o) && $stable(last_o))
    else $error("stalled output changed");

  // input is held off while a burst is still draining
  a_burst_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input open during payload burst");

  // burst has no gaps once a byte is taken
  a_burst_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside payload burst");

  // indexes step by one within a burst
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      byte_index_o == $past(byte_index_o) + 4'd1)
    else $error("byte index did not advance");

endmodule

bind sum8_packet_deframer sdf_checker u_sdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .payload_byte_o (payload_byte_o),
  .byte_index_o   (byte_index_o),
  .last_o         (last_o)
);
